FILE: rtl/dbq_pkg.sv
// Shared types, sizes and constants for the dial and button input qualifier.
// No dependencies; imported by every module of the block.
package dbq_pkg;

    localparam int DIAL_COUNT   = 4;
    localparam int BUTTON_COUNT = 7;
    localparam int COUNTS_W     = 12;
    localparam int POS_W        = 4;
    localparam int TIME_W       = 32;
    localparam int MAXMS_W      = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int THRESH_N     = 11;

    // Register indexes of the configuration port
    localparam logic REG_TIMEOUT_MASK = 1'b0;
    localparam logic REG_MAX_ACTIVE   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] TIMEOUT_MASK_RESET = 16'd96;
    localparam logic [MAXMS_W-1:0]    MAX_ACTIVE_RESET   = 16'd200;

    localparam logic [POS_W-1:0] POS_LOWEST = 4'd12;

    typedef logic [COUNTS_W-1:0] counts_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [TIME_W-1:0]   ms_t;

    typedef counts_t thresh_tab_t [THRESH_N];

    // Descending quantizer thresholds, position k+1 when counts exceed entry k
    localparam thresh_tab_t DIAL_THRESH = '{
        12'd3909, 12'd3537, 12'd3164, 12'd2792, 12'd2419, 12'd2048,
        12'd1675, 12'd1303, 12'd931,  12'd558,  12'd186
    };

    typedef struct packed {
        logic [BUTTON_COUNT-1:0] timeout_mask;
        logic [MAXMS_W-1:0]      max_active_ms;
    } cfg_t;

    // First threshold exceeded wins; below all of them is the lowest position
    function automatic pos_t quantize_dial(input counts_t counts);
        pos_t pos;
        pos = POS_LOWEST;
        for (int k = THRESH_N - 1; k >= 0; k--) begin
            if (counts > DIAL_THRESH[k]) begin
                pos = POS_W'(k + 1);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/dbq_dial_filter.sv
// Dial quantizer and two-reading agreement filter, one lane per dial.
// Depends on dbq_pkg.
module dbq_dial_filter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  dbq_pkg::counts_t                      counts [dbq_pkg::DIAL_COUNT],
    output dbq_pkg::pos_t                         position_next [dbq_pkg::DIAL_COUNT]
);
    import dbq_pkg::*;

    pos_t position_reg [DIAL_COUNT];
    pos_t last_reg     [DIAL_COUNT];
    pos_t reading      [DIAL_COUNT];

    always_comb
    begin
        for (int i = 0; i < DIAL_COUNT; i++) begin
            reading[i] = quantize_dial(counts[i]);
            if (reading[i] == last_reg[i]) begin
                position_next[i] = reading[i];
            end else begin
                position_next[i] = position_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DIAL_COUNT; i++) begin
                position_reg[i] <= '0;
                last_reg[i]     <= '0;
            end
        end else if (step) begin
            for (int i = 0; i < DIAL_COUNT; i++) begin
                position_reg[i] <= position_next[i];
                last_reg[i]     <= reading[i];
            end
        end
    end

endmodule

FILE: rtl/dbq_button_filter.sv
// Button inversion, debounce, press timing and timeout cut-off.
// Depends on dbq_pkg.
module dbq_button_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  dbq_pkg::cfg_t                     cfg,
    input  logic [dbq_pkg::BUTTON_COUNT-1:0]  pin_levels,
    input  dbq_pkg::ms_t                      now_ms,
    output logic [dbq_pkg::BUTTON_COUNT-1:0]  active_next
);
    import dbq_pkg::*;

    logic [BUTTON_COUNT-1:0] state_reg;
    logic [BUTTON_COUNT-1:0] last_reg;
    ms_t                     start_reg [BUTTON_COUNT];

    logic [BUTTON_COUNT-1:0] reading;
    logic [BUTTON_COUNT-1:0] state_next;
    logic [BUTTON_COUNT-1:0] last_next;
    ms_t                     start_next [BUTTON_COUNT];
    ms_t                     held_ms    [BUTTON_COUNT];
    logic                    limit_on;

    assign reading  = ~pin_levels;
    assign limit_on = (cfg.max_active_ms != '0);

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            state_next[i] = state_reg[i];
            last_next[i]  = last_reg[i];
            start_next[i] = start_reg[i];
            // last reading only moves while the pin disagrees with the state
            if (reading[i] != state_reg[i]) begin
                last_next[i] = reading[i];
                if (reading[i] == last_reg[i]) begin
                    state_next[i] = reading[i];
                    if (reading[i]) begin
                        start_next[i] = now_ms;
                    end
                end
            end
            held_ms[i] = now_ms - start_next[i];
            active_next[i] = state_next[i] &&
                !(cfg.timeout_mask[i] && limit_on &&
                  (held_ms[i] >= {{(TIME_W - MAXMS_W){1'b0}}, cfg.max_active_ms}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
            last_reg  <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                start_reg[i] <= '0;
            end
        end else if (step) begin
            state_reg <= state_next;
            last_reg  <= last_next;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                start_reg[i] <= start_next[i];
            end
        end
    end

endmodule

FILE: rtl/dial_and_button_input_qualifier.sv
// Top level of the dial and button input qualifier: input register, config
// registers, result register. Depends on dbq_pkg, dbq_dial_filter, dbq_button_filter.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one polling tick: four 12-bit
//   dial samples, seven active-low pin levels and the millisecond time.
//   Output channel (out_valid/out_ready) carries one result per tick: four
//   debounced dial positions and the qualified button bits.
//   Config port (cfg_we/cfg_index/cfg_data) writes timeout_mask (index 0)
//   or max_active_ms (index 1) in the cycle cfg_we is high; write only while
//   no tick is in flight.
//   Path: an accepted tick passes through the input register, then the result
//   register. Throughput is one tick per cycle while out_ready stays high; the
//   whole filter update is one pass of compare and subtract logic between the
//   two registers, gated by the 32-bit press-time subtraction.
//   Reset clears all filter state, empties both stages and loads the config
//   defaults (mask 96, max time 200 ms).
//   Stall: when out_ready is low and a result waits, the input register
//   still takes one more tick, then in_ready drops until the result is taken.
//   Filter state advances only when a tick moves into the result register.
module dial_and_button_input_qualifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dbq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial0_counts,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial1_counts,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial2_counts,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial3_counts,
    input  logic [dbq_pkg::BUTTON_COUNT-1:0]     pin_levels,
    input  logic [dbq_pkg::TIME_W-1:0]           now_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dbq_pkg::POS_W-1:0]            dial0_position,
    output logic [dbq_pkg::POS_W-1:0]            dial1_position,
    output logic [dbq_pkg::POS_W-1:0]            dial2_position,
    output logic [dbq_pkg::POS_W-1:0]            dial3_position,
    output logic [dbq_pkg::BUTTON_COUNT-1:0]     buttons_active
);
    import dbq_pkg::*;

    // config registers
    cfg_t cfg_reg;

    // input stage
    logic                    s1_valid_reg;
    counts_t                 s1_counts_reg [DIAL_COUNT];
    logic [BUTTON_COUNT-1:0] s1_pins_reg;
    ms_t                     s1_now_reg;

    // result stage
    logic                    out_valid_reg;
    pos_t                    out_pos_reg [DIAL_COUNT];
    logic [BUTTON_COUNT-1:0] out_active_reg;

    logic                    s1_advance;
    logic                    in_xfer;
    pos_t                    pos_next [DIAL_COUNT];
    logic [BUTTON_COUNT-1:0] active_next;

    // tick moves to the result register when that register is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.timeout_mask  <= TIMEOUT_MASK_RESET[BUTTON_COUNT-1:0];
            cfg_reg.max_active_ms <= MAX_ACTIVE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TIMEOUT_MASK: cfg_reg.timeout_mask  <= cfg_data[BUTTON_COUNT-1:0];
                REG_MAX_ACTIVE:   cfg_reg.max_active_ms <= cfg_data[MAXMS_W-1:0];
                default:          cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            s1_counts_reg[0] <= dial0_counts;
            s1_counts_reg[1] <= dial1_counts;
            s1_counts_reg[2] <= dial2_counts;
            s1_counts_reg[3] <= dial3_counts;
            s1_pins_reg      <= pin_levels;
            s1_now_reg       <= now_ms;
        end
        if (s1_advance) begin
            for (int i = 0; i < DIAL_COUNT; i++) begin
                out_pos_reg[i] <= pos_next[i];
            end
            out_active_reg <= active_next;
        end
    end

    dbq_dial_filter u_dials (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_advance),
        .counts        (s1_counts_reg),
        .position_next (pos_next)
    );

    dbq_button_filter u_buttons (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_advance),
        .cfg         (cfg_reg),
        .pin_levels  (s1_pins_reg),
        .now_ms      (s1_now_reg),
        .active_next (active_next)
    );

    assign out_valid      = out_valid_reg;
    assign dial0_position = out_pos_reg[0];
    assign dial1_position = out_pos_reg[1];
    assign dial2_position = out_pos_reg[2];
    assign dial3_position = out_pos_reg[3];
    assign buttons_active = out_active_reg;

    // a new result only appears after a tick left the input stage
    a_rose_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_advance))
        else $error("result appeared without a transfer from the input stage");

    // a held tick is never dropped
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("input stage lost a waiting tick");

    // overwriting a full input stage requires it to move on in the same cycle
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s1_valid_reg) |-> s1_advance)
        else $error("input stage overwritten while full");

    // positions stay in range once a result is offered
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pos_reg[0] <= POS_LOWEST && out_pos_reg[1] <= POS_LOWEST &&
                           out_pos_reg[2] <= POS_LOWEST && out_pos_reg[3] <= POS_LOWEST))
        else $error("dial position out of range");

endmodule

FILE: bench/dbq_readout_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the dial and button input qualifier: mirrors the filter state,
// predicts each readout and compares it with the block's output. Depends on dbq_pkg.
module dbq_readout_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dbq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial0_counts,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial1_counts,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial2_counts,
    input  logic [dbq_pkg::COUNTS_W-1:0]         dial3_counts,
    input  logic [dbq_pkg::BUTTON_COUNT-1:0]     pin_levels,
    input  logic [dbq_pkg::TIME_W-1:0]           now_ms,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [dbq_pkg::POS_W-1:0]            dial0_position,
    input  logic [dbq_pkg::POS_W-1:0]            dial1_position,
    input  logic [dbq_pkg::POS_W-1:0]            dial2_position,
    input  logic [dbq_pkg::POS_W-1:0]            dial3_position,
    input  logic [dbq_pkg::BUTTON_COUNT-1:0]     buttons_active,
    output int                                   readout_faults,
    output int                                   readouts_owed
);
    import dbq_pkg::*;

    localparam int REPORT_MAX = 10;

    // index 0 holds the highest edge
    localparam logic [THRESH_N-1:0][COUNTS_W-1:0] STEP_EDGES = {
        12'd186,  12'd558,  12'd931,  12'd1303, 12'd1675, 12'd2048,
        12'd2419, 12'd2792, 12'd3164, 12'd3537, 12'd3909
    };

    typedef struct packed {
        pos_t [DIAL_COUNT-1:0]   pos;
        logic [BUTTON_COUNT-1:0] active;
    } readout_t;

    readout_t                pending_readouts [$];
    pos_t                    dial_pos  [DIAL_COUNT];
    pos_t                    dial_prev [DIAL_COUNT];
    logic [BUTTON_COUNT-1:0] btn_on;
    logic [BUTTON_COUNT-1:0] btn_prev;
    ms_t                     press_t [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] cut_mask;
    logic [MAXMS_W-1:0]      hold_limit;

    initial readout_faults = 0;
    initial readouts_owed  = 0;

    function automatic pos_t dial_step(input counts_t c);
        pos_t p;
        bit   found;
        p     = POS_LOWEST;
        found = 1'b0;
        for (int k = 0; k < THRESH_N; k++) begin
            if (!found && c > STEP_EDGES[k]) begin
                p     = pos_t'(k + 1);
                found = 1'b1;
            end
        end
        return p;
    endfunction

    // One polling tick: dials, then buttons, then the press timeout at this tick's time
    task automatic qualify_tick(input logic [DIAL_COUNT-1:0][COUNTS_W-1:0] samples,
                                input logic [BUTTON_COUNT-1:0] pins, input ms_t t,
                                output readout_t res);
        pos_t r;
        logic pressed;
        ms_t  held;
        for (int i = 0; i < DIAL_COUNT; i++) begin
            r = dial_step(samples[i]);
            if (r != dial_pos[i] && r == dial_prev[i]) begin
                dial_pos[i] = r;
            end
            dial_prev[i] = r;
            res.pos[i]   = dial_pos[i];
        end
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            pressed = ~pins[i];
            // last reading only moves while the reading disagrees with the state
            if (pressed != btn_on[i]) begin
                if (pressed == btn_prev[i]) begin
                    btn_on[i] = pressed;
                    if (pressed) begin
                        press_t[i] = t;
                    end
                end
                btn_prev[i] = pressed;
            end
        end
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            held          = t - press_t[i];
            res.active[i] = btn_on[i] &&
                            !(cut_mask[i] && hold_limit != '0 && held >= ms_t'(hold_limit));
        end
    endtask

    task automatic note_fault(input string why, input readout_t want, input readout_t got);
        readout_faults++;
        if (readout_faults <= REPORT_MAX) begin
            $display("%0t: %s: expected pos %0d/%0d/%0d/%0d buttons %b, got pos %0d/%0d/%0d/%0d buttons %b",
                     $realtime, why, want.pos[0], want.pos[1], want.pos[2], want.pos[3],
                     want.active, got.pos[0], got.pos[1], got.pos[2], got.pos[3], got.active);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        readout_t want;
        readout_t got;
        if (!rst_n) begin
            for (int i = 0; i < DIAL_COUNT; i++) begin
                dial_pos[i]  = '0;
                dial_prev[i] = '0;
            end
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                press_t[i] = '0;
            end
            btn_on     = '0;
            btn_prev   = '0;
            cut_mask   = TIMEOUT_MASK_RESET[BUTTON_COUNT-1:0];
            hold_limit = MAX_ACTIVE_RESET;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TIMEOUT_MASK) begin
                    cut_mask = cfg_data[BUTTON_COUNT-1:0];
                end else if (cfg_index == REG_MAX_ACTIVE) begin
                    hold_limit = cfg_data[MAXMS_W-1:0];
                end
            end
            if (in_valid && in_ready) begin
                qualify_tick({dial3_counts, dial2_counts, dial1_counts, dial0_counts},
                             pin_levels, now_ms, want);
                pending_readouts.push_back(want);
            end
            if (out_valid && out_ready) begin
                got.pos[0] = dial0_position;
                got.pos[1] = dial1_position;
                got.pos[2] = dial2_position;
                got.pos[3] = dial3_position;
                got.active = buttons_active;
                if (pending_readouts.size() == 0) begin
                    note_fault("readout with none expected", '0, got);
                end else begin
                    want = pending_readouts.pop_front();
                    if (got !== want) begin
                        note_fault("readout mismatch", want, got);
                    end
                end
            end
        end
        readouts_owed = pending_readouts.size();
    end

endmodule

FILE: bench/dial_and_button_input_qualifier_tb.sv
`timescale 1ns / 1ps
// Top of the dial and button input qualifier bench: clock, reset, polling stimulus,
// backpressure and verdict. Depends on dbq_pkg, the block and dbq_readout_checker.
module dial_and_button_input_qualifier_tb;
    import dbq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
    localparam int PHASE_POLLS = 300;     // five phases, about 1500 random polls
    localparam int TAIL_CYCLES = 10;      // pipeline is two stages deep

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [COUNTS_W-1:0]     dial0_counts;
    logic [COUNTS_W-1:0]     dial1_counts;
    logic [COUNTS_W-1:0]     dial2_counts;
    logic [COUNTS_W-1:0]     dial3_counts;
    logic [BUTTON_COUNT-1:0] pin_levels;
    logic [TIME_W-1:0]       now_ms;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [POS_W-1:0]        dial0_position;
    logic [POS_W-1:0]        dial1_position;
    logic [POS_W-1:0]        dial2_position;
    logic [POS_W-1:0]        dial3_position;
    logic [BUTTON_COUNT-1:0] buttons_active;
    int                      readout_faults;
    int                      readouts_owed;

    // Pacing knobs, percent of cycles spent idle (sender) or stalled (receiver)
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    int                      cycle_count    = 0;

    // Random stimulus memory: each dial rests on a value for a while, each
    // button has a held level that bounces now and then, time mostly creeps up.
    counts_t                 dial_aim [DIAL_COUNT];
    logic [BUTTON_COUNT-1:0] pin_hold;
    ms_t                     clock_ms;

    dial_and_button_input_qualifier DUT (.*);

    dbq_readout_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver side: out_ready redrawn every cycle from the stall percentage
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One polling tick through the input channel. Random idle cycles come
    // first; valid then stays high until the transfer. in_ready is looked at
    // on the falling edge where everything has settled.
    task automatic send_poll(input counts_t d0, input counts_t d1, input counts_t d2,
                             input counts_t d3, input logic [BUTTON_COUNT-1:0] pins,
                             input ms_t t);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        dial0_counts <= d0;
        dial1_counts <= d1;
        dial2_counts <= d2;
        dial3_counts <= d3;
        pin_levels   <= pins;
        now_ms       <= t;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    // Random tick: mostly settled dials and held buttons with some noise, so
    // the debounce paths get past their first reading.
    task automatic send_random_poll();
        counts_t smp [DIAL_COUNT];
        logic [BUTTON_COUNT-1:0] pins;
        int roll;
        for (int k = 0; k < DIAL_COUNT; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    // land right around a quantizer edge
                    dial_aim[k] = counts_t'(int'(DIAL_THRESH[$urandom_range(0, THRESH_N - 1)])
                                  + int'($urandom_range(0, 2)) - 1);
                end else begin
                    dial_aim[k] = counts_t'($urandom_range(0, 4095));
                end
            end
            smp[k] = ($urandom_range(0, 9) == 0) ? counts_t'($urandom_range(0, 4095))
                                                  : dial_aim[k];
        end
        for (int k = 0; k < BUTTON_COUNT; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                pin_hold[k] = ~pin_hold[k];
            end
        end
        pins = pin_hold;
        for (int k = 0; k < BUTTON_COUNT; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                pins[k] = ~pins[k];  // single-tick bounce
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            clock_ms = $urandom();  // arbitrary jump, exercises wrapped durations
        end else if (roll < 20) begin
            clock_ms = clock_ms + $urandom_range(0, 3000);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 40);
        end
        send_poll(smp[0], smp[1], smp[2], smp[3], pins, clock_ms);
    endtask

    // Sender holds off until every readout is back; block is idle after this
    task automatic wait_all_readouts();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (readouts_owed != 0);
        @(posedge clk);
    endtask

    // Both registers, back to back, write enable held across both writes
    task automatic set_limits(input logic [BUTTON_COUNT-1:0] mask,
                              input logic [MAXMS_W-1:0] limit_ms);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIMEOUT_MASK;
        cfg_data  <= CFG_DATA_W'(mask);
        @(posedge clk);
        cfg_index <= REG_MAX_ACTIVE;
        cfg_data  <= CFG_DATA_W'(limit_ms);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [BUTTON_COUNT-1:0] mask,
                             input logic [MAXMS_W-1:0] limit_ms);
        set_limits(mask, limit_ms);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_POLLS) send_random_poll();
        wait_all_readouts();
    endtask

    initial begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_TIMEOUT_MASK;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        dial0_counts <= '0;
        dial1_counts <= '0;
        dial2_counts <= '0;
        dial3_counts <= '0;
        pin_levels   <= '1;
        now_ms       <= '0;
        pin_hold     = '1;
        clock_ms     = 32'd500;
        for (int k = 0; k < DIAL_COUNT; k++) begin
            dial_aim[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset limits: buttons 5 and 6 cut off at 200 ms.
        // Dials at the count extremes and exactly on / one above an edge.
        send_poll(12'd0,    12'd4095, 12'd186,  12'd187,  7'h7F, 32'd0);
        send_poll(12'd0,    12'd4095, 12'd186,  12'd187,  7'h00, 32'd1);
        // all buttons pressed twice -> active, press starts at 2
        send_poll(12'd3909, 12'd3910, 12'd2048, 12'd2049, 7'h00, 32'd2);
        send_poll(12'd3909, 12'd3910, 12'd2048, 12'd2049, 7'h00, 32'd100);
        // 199 ms held: still on; 200 ms: masked buttons drop
        send_poll(12'd3909, 12'd3910, 12'd2048, 12'd2049, 7'h00, 32'd201);
        send_poll(12'd0,    12'd3910, 12'd2048, 12'd2049, 7'h00, 32'd202);
        // dial 0 alternates and never settles; buttons release
        send_poll(12'd4095, 12'd3910, 12'd2048, 12'd2049, 7'h7F, 32'd203);
        send_poll(12'd0,    12'd3910, 12'd2048, 12'd2049, 7'h7F, 32'd204);
        // debounce memory: press, release, press -> the second press activates
        send_poll(12'd4095, 12'd3910, 12'd2048, 12'd2049, 7'h7E, 32'd205);
        send_poll(12'd0,    12'd3910, 12'd2048, 12'd2049, 7'h7F, 32'd206);
        send_poll(12'd4095, 12'd3910, 12'd2048, 12'd2049, 7'h7E, 32'd207);
        // timer wrap on button 6: press starts just below 2^32
        send_poll(12'd1303, 12'd931,  12'd558,  12'd1675, 7'h7F, 32'd208);
        send_poll(12'd1303, 12'd931,  12'd558,  12'd1675, 7'h3F, 32'hFFFF_FFA0);
        send_poll(12'd1303, 12'd931,  12'd558,  12'd1675, 7'h3F, 32'hFFFF_FFA1);
        send_poll(12'd1303, 12'd931,  12'd558,  12'd1675, 7'h3F, 32'h0000_0010);
        send_poll(12'd1303, 12'd931,  12'd558,  12'd1675, 7'h3F, 32'h0000_0068);
        send_poll(12'd1303, 12'd931,  12'd558,  12'd1675, 7'h3F, 32'h0000_0069);
        send_poll(12'd4095, 12'd0,    12'd4095, 12'd0,    7'h7F, 32'hFFFF_FFFF);
        send_poll(12'd4095, 12'd0,    12'd4095, 12'd0,    7'h7F, 32'hFFFF_FFFF);
        // alternating pin patterns, remaining edges
        send_poll(12'd3164, 12'd3537, 12'd2792, 12'd2419, 7'h55, 32'd0);
        send_poll(12'd3164, 12'd3537, 12'd2792, 12'd2419, 7'h2A, 32'd0);
        wait_all_readouts();  // sender held off until every readout is back

        // Random phases, limits changed only between them
        run_phase(0,  0,  7'h7F, 16'd100);
        run_phase(48, 0,  7'h00, 16'hFFFF);
        run_phase(0,  48, BUTTON_COUNT'($urandom_range(1, 126)), 16'd0);  // no cut-off
        run_phase(9,  9,  7'h7F, 16'd1);
        clock_ms = 32'hFFFF_F000;  // cross the 32-bit wrap with live presses
        run_phase(0,  0,  BUTTON_COUNT'($urandom_range(0, 127)),
                  MAXMS_W'($urandom_range(20, 400)));

        // nothing may come out once all readouts are in
        repeat (TAIL_CYCLES) @(posedge clk);
        if (readout_faults == 0 && readouts_owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: dial_and_button_input_qualifier.f
rtl/dbq_pkg.sv
rtl/dbq_dial_filter.sv
rtl/dbq_button_filter.sv
rtl/dial_and_button_input_qualifier.sv
bench/dbq_readout_checker.sv
bench/dial_and_button_input_qualifier_tb.sv
